@@ design/format_string_number_printer_top_assert.svh @@
// Assertion macros for the format string number printer.
// Used by format_string_number_printer_top; expects a clock clk and reset rst.
`ifndef FORMAT_STRING_NUMBER_PRINTER_TOP_ASSERT_SVH
`define FORMAT_STRING_NUMBER_PRINTER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define FSNP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsnp assertion failed");
// Next-cycle implication.
`define FSNP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsnp assertion failed");
`else
`define FSNP_ASSERT_NOW(label, ante, cons)
`define FSNP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ design/fsnp_pkg.sv @@
// Shared types and constants for the format string number printer.
// No dependencies; imported by every module of the block.
package fsnp_pkg;

  // Command kinds handed from the front to the back.
  typedef enum logic [2:0] {
    CMD_ECHO,
    CMD_DEC,
    CMD_HEX,
    CMD_BIN,
    CMD_STR,
    CMD_MARK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  ch;
    logic [15:0] arg;
    logic        taken;
  } cmd_t;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LOW_D   = 8'h64;
  localparam logic [7:0] CH_LOW_X   = 8'h78;
  localparam logic [7:0] CH_LOW_B   = 8'h62;
  localparam logic [7:0] CH_LOW_S   = 8'h73;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UP_A    = 8'h41;

  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;
  localparam int DEC_STEPS = 16;

endpackage

@@ design/fsnp_front.sv @@
// Front end: accepts format characters and classifies them into commands.
// Depends on fsnp_pkg; feeds fsnp_queue.
module fsnp_front
  import fsnp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  fmt_char,
  input  logic [15:0] arg_value,
  input  logic        first_of_format,
  output logic        push,
  input  logic        push_ready,
  output cmd_t        push_cmd
);

  logic percent_pending;
  logic percent_pending_next;
  logic pend_eff;
  logic accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign pend_eff = percent_pending && !first_of_format;

  always_comb begin
    push                 = 1'b0;
    percent_pending_next = percent_pending;
    push_cmd.kind        = CMD_ECHO;
    push_cmd.ch          = fmt_char;
    push_cmd.arg         = arg_value;
    push_cmd.taken       = 1'b0;
    if (accept) begin
      percent_pending_next = (fmt_char == CH_PERCENT);
      if (!pend_eff) begin
        // plain percent arms the conversion and emits nothing
        push = (fmt_char != CH_PERCENT);
      end else begin
        push           = 1'b1;
        push_cmd.taken = 1'b1;
        unique case (fmt_char)
          CH_LOW_D:   push_cmd.kind = CMD_DEC;
          CH_LOW_X:   push_cmd.kind = CMD_HEX;
          CH_LOW_B:   push_cmd.kind = CMD_BIN;
          CH_LOW_S:   push_cmd.kind = CMD_STR;
          CH_PERCENT: push_cmd.kind = CMD_MARK;
          default:    push_cmd.kind = CMD_ECHO;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      percent_pending <= 1'b0;
    end else begin
      percent_pending <= percent_pending_next;
    end
  end

endmodule

@@ design/fsnp_queue.sv @@
// Two-entry command queue between front and back.
// Depends on fsnp_pkg.
module fsnp_queue
  import fsnp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign in_ready  = (count != QCNT_W'(QDEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = slots[rd_ptr];
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/fsnp_back.sv @@
// Back end: runs one command, converts numbers and emits one character per beat.
// Depends on fsnp_pkg; fed by fsnp_queue.
module fsnp_back
  import fsnp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        char_valid,
  output logic        arg_taken,
  output logic        string_request,
  output logic [15:0] string_address,
  output logic        last
);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_t;

  state_t      state;
  cmd_t        cmd;
  logic [19:0] bcd;
  logic [15:0] sh;
  logic [3:0]  step;
  logic [4:0]  idx;
  logic        neg;

  logic [19:0] bcd_adj;
  logic [15:0] mag;
  logic [2:0]  nd;
  logic [4:0]  total;
  logic [4:0]  pos;
  logic [3:0]  digit;
  logic [7:0]  emit_char;
  logic        out_free;
  logic        is_last;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d <= 4'd9) begin
      return CH_ZERO + {4'b0, d};
    end
    return CH_UP_A + {4'b0, d} - 8'd10;
  endfunction

  // add-3 correction of each decimal digit before the shift
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  assign mag = cmd_in.arg[15] ? (16'd0 - cmd_in.arg) : cmd_in.arg;

  always_comb begin
    priority if (bcd[19:16] != 4'd0) nd = 3'd5;
    else if (bcd[15:12] != 4'd0)     nd = 3'd4;
    else if (bcd[11:8] != 4'd0)      nd = 3'd3;
    else if (bcd[7:4] != 4'd0)       nd = 3'd2;
    else                             nd = 3'd1;
  end

  always_comb begin
    unique case (cmd.kind)
      CMD_DEC: total = {2'b0, nd} + {4'b0, neg};
      CMD_HEX: total = 5'd6;
      CMD_BIN: total = 5'd17;
      default: total = 5'd1;
    endcase
  end

  assign pos     = total - 5'd1 - idx;
  assign is_last = (pos == 5'd0);

  always_comb begin
    unique case (pos[2:0])
      3'd0:    digit = bcd[3:0];
      3'd1:    digit = bcd[7:4];
      3'd2:    digit = bcd[11:8];
      3'd3:    digit = bcd[15:12];
      3'd4:    digit = bcd[19:16];
      default: digit = 4'd0;
    endcase
  end

  always_comb begin
    unique case (cmd.kind)
      CMD_DEC: emit_char = (pos < {2'b0, nd}) ? CH_ZERO + {4'b0, digit} : CH_MINUS;
      CMD_HEX: begin
        if (pos == 5'd5) begin
          emit_char = CH_ZERO;
        end else if (pos == 5'd4) begin
          emit_char = CH_LOW_X;
        end else begin
          emit_char = hex_char(cmd.arg[pos[1:0]*4 +: 4]);
        end
      end
      CMD_BIN: begin
        if (pos == 5'd0) begin
          emit_char = CH_LOW_B;
        end else begin
          emit_char = CH_ZERO + {7'b0, cmd.arg[pos[3:0] - 4'd1]};
        end
      end
      CMD_ECHO: emit_char = cmd.ch;
      default:  emit_char = 8'd0;
    endcase
  end

  assign cmd_ready = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // load a new beat, or drop the one just taken
      if ((state == ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd   <= cmd_in;
            neg   <= (cmd_in.kind == CMD_DEC) && cmd_in.arg[15];
            sh    <= mag;
            bcd   <= '0;
            step  <= '0;
            idx   <= '0;
            state <= (cmd_in.kind == CMD_DEC) ? ST_CONV : ST_EMIT;
          end
        end
        ST_CONV: begin
          bcd  <= {bcd_adj[18:0], sh[15]};
          sh   <= {sh[14:0], 1'b0};
          step <= step + 4'd1;
          if (step == 4'(DEC_STEPS - 1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_char       <= emit_char;
            char_valid     <= (cmd.kind != CMD_STR) && (cmd.kind != CMD_MARK);
            arg_taken      <= cmd.taken;
            string_request <= (cmd.kind == CMD_STR);
            string_address <= (cmd.kind == CMD_STR) ? cmd.arg : 16'd0;
            last           <= is_last;
            idx            <= idx + 5'd1;
            if (is_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/format_string_number_printer_top.sv @@
// Format string number printer: one format character in, a run of text beats out.
// Depends on fsnp_pkg, fsnp_front, fsnp_queue, fsnp_back and the assertion header.
//
// Feed the format string one character per beat on the s_ side, with the current
// argument word beside it; set s_tuser on the first character of a new format to
// drop any half-open conversion. Ordinary characters come back as one beat each, a
// lone percent sign produces nothing, and the letter after it consumes the argument:
// d prints signed decimal (0x8000 prints -32768), x prints 0x and four upper-case
// hex digits, b prints sixteen binary digits and a trailing b, s returns one beat
// with string_request set and the argument as string_address for an outside string
// printer. m_tlast marks the final beat caused by each input character. Within a
// run the output side emits one beat per cycle while m_tready is high; the back end
// picks up each command in its idle state before it converts or emits, and the
// decimal conversion is a sixteen-step shift-and-add-3 loop in the back end.
// A two-entry command queue lets the front accept characters while the back end is
// still converting or stalled.
`include "format_string_number_printer_top_assert.svh"

module format_string_number_printer_top
  import fsnp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] fmt_char, [23:8] arg_value
  input  logic        s_tuser,   // [0] first_of_format
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] out_char, [8] arg_taken, [24:9] string_address
  output logic [1:0]  m_tuser,   // [0] char_valid, [1] string_request
  output logic        m_tlast
);

  logic        push;
  logic        push_ready;
  cmd_t        push_cmd;
  logic        q_valid;
  logic        q_ready;
  cmd_t        q_cmd;
  logic [7:0]  out_char;
  logic        char_valid;
  logic        arg_taken;
  logic        string_request;
  logic [15:0] string_address;

  // Classify characters and track the pending percent.
  fsnp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .fmt_char        (s_tdata[7:0]),
    .arg_value       (s_tdata[23:8]),
    .first_of_format (s_tuser),
    .push            (push),
    .push_ready      (push_ready),
    .push_cmd        (push_cmd)
  );

  // Hold commands while the back end works.
  fsnp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_ready  (push_ready),
    .in_cmd    (push_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  // Convert and emit beats through the output register.
  fsnp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (q_valid),
    .cmd_ready      (q_ready),
    .cmd_in         (q_cmd),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_char       (out_char),
    .char_valid     (char_valid),
    .arg_taken      (arg_taken),
    .string_request (string_request),
    .string_address (string_address),
    .last           (m_tlast)
  );

  assign m_tdata = {7'b0, string_address, arg_taken, out_char};
  assign m_tuser = {string_request, char_valid};

  // A string request is a lone beat without a character.
  `FSNP_ASSERT_NOW(a_sreq_alone, m_tvalid && m_tuser[1], m_tlast && !m_tuser[0])
  // A beat without a character only comes from a consumed argument.
  `FSNP_ASSERT_NOW(a_nochar_taken, m_tvalid && !m_tuser[0], m_tdata[8])
  // Within a run the next beat follows at once.
  `FSNP_ASSERT_NEXT(a_run_dense, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule
